// File: hdl/pgm_pkg.sv
// ----------------------------------------------------------------------------
// pgm_pkg: shared types and constants for the P5 header parser
// Parse phases, verdict codes and the byte values the parser looks for.
// ----------------------------------------------------------------------------
`default_nettype none

package pgm_pkg;

  typedef enum logic [2:0] {
    PH_MAGIC_P,
    PH_MAGIC_5,
    PH_SKIP,
    PH_COMMENT,
    PH_DIGITS,
    PH_PIXELS
  } phase_t;

  typedef logic [2:0] err_t;

  localparam err_t ERR_NONE      = 3'd0;
  localparam err_t ERR_MAGIC     = 3'd1;
  localparam err_t ERR_NUMBER    = 3'd2;
  localparam err_t ERR_DIMS      = 3'd3;
  localparam err_t ERR_SEPARATOR = 3'd4;
  localparam err_t ERR_TRUNCATED = 3'd5;

  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_5     = 8'h35;
  localparam logic [7:0] CHAR_HASH  = 8'h23;
  localparam logic [7:0] CHAR_LF    = 8'h0a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [23:0] NUM_LIMIT     = 24'hffffff;
  localparam logic [23:0] DIM_LIMIT     = 24'h00ffff;
  localparam logic [23:0] MAXVAL_NEEDED = 24'd255;
  localparam int          MIN_FILE_BYTES = 8;

endpackage

`default_nettype wire

// File: hdl/pgm_p5_header_parser_top.sv
// ----------------------------------------------------------------------------
// pgm_p5_header_parser_top: binary grayscale image header checker
// Parses the P5 magic, width, height and maxval of a byte stream, counts the
// pixel bytes and gives one verdict on the final byte of each file.
// ----------------------------------------------------------------------------
//
//  Channel   Handshake                    Payload
//  -------   --------------------------   ---------------------------------
//  byte      byte_valid / byte_stall      data_byte, last_byte
//  verdict   verdict_valid / verdict_stall header_ok, error_code,
//                                          image_width, image_height,
//                                          pixel_offset
//
// One byte is taken per cycle while byte_stall is low; the parse state advances
// at the byte transfer and a verdict appears in the output register on the cycle
// after the last byte. The width*height product is registered from the parsed
// dimensions, so the pixel-count check costs no multiplier on the byte path.
// Reset (rst, synchronous) starts the parser at the magic and empties the
// verdict register. Ordinary bytes keep flowing while a verdict waits; only a
// last byte is held back while an untaken verdict sits in the output.
// ----------------------------------------------------------------------------
`default_nettype none

module pgm_p5_header_parser_top
  import pgm_pkg::*;
#(
  parameter int COUNT_BITS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        byte_valid,
  output logic             byte_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        last_byte,
  output logic             verdict_valid,
  input  wire logic        verdict_stall,
  output logic             header_ok,
  output logic [2:0]       error_code,
  output logic [15:0]      image_width,
  output logic [15:0]      image_height,
  output logic [31:0]      pixel_offset
);

  localparam int DIFF_W = (COUNT_BITS > 32) ? COUNT_BITS : 32;

  // parse state
  phase_t                  phase, phase_next;
  logic [1:0]              number_index, number_index_next;
  logic [23:0]             digit_acc, digit_acc_next;
  logic [15:0]             width_value, width_value_next;
  logic [15:0]             height_value, height_value_next;
  logic                    dims_bad, dims_bad_next;
  logic [COUNT_BITS-1:0]   byte_counter, byte_counter_next;
  logic [COUNT_BITS-1:0]   pixel_counter, pixel_counter_next;
  err_t                    first_error, error_next;
  err_t                    verdict_code;
  logic [31:0]             dims_product;

  // byte classification
  logic                    is_ws, is_digit;
  logic [27:0]             acc_sum;
  logic                    do_skip;
  logic                    byte_accept;
  logic [DIFF_W-1:0]       offset_wide;

  assign byte_accept = byte_valid && !byte_stall;
  // hold a last byte only while the verdict register is occupied and blocked
  assign byte_stall  = verdict_valid && verdict_stall && last_byte;

  assign is_ws    = (data_byte == CHAR_SPACE) ||
                    ((data_byte >= CHAR_TAB) && (data_byte <= CHAR_CR));
  assign is_digit = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
  // acc*10 + digit
  assign acc_sum  = {1'b0, digit_acc, 3'b000} + {3'b000, digit_acc, 1'b0} +
                    {24'd0, data_byte[3:0]};

  // -- per-byte step, then the end-of-file verdict on the stepped state ----
  always_comb begin
    phase_next         = phase;
    number_index_next  = number_index;
    digit_acc_next     = digit_acc;
    width_value_next   = width_value;
    height_value_next  = height_value;
    dims_bad_next      = dims_bad;
    pixel_counter_next = pixel_counter;
    error_next         = first_error;
    do_skip            = 1'b0;
    verdict_code       = ERR_NONE;

    // saturate the file length
    if (~&byte_counter) begin
      byte_counter_next = byte_counter + {{(COUNT_BITS-1){1'b0}}, 1'b1};
    end else begin
      byte_counter_next = byte_counter;
    end

    if (first_error == ERR_NONE) begin
      case (phase)
        PH_MAGIC_P: begin
          if (data_byte == CHAR_P) phase_next = PH_MAGIC_5;
          else                     error_next = ERR_MAGIC;
        end
        PH_MAGIC_5: begin
          if (data_byte == CHAR_5) phase_next = PH_SKIP;
          else                     error_next = ERR_MAGIC;
        end
        PH_SKIP: begin
          do_skip = 1'b1;
        end
        PH_COMMENT: begin
          if (data_byte == CHAR_LF) phase_next = PH_SKIP;
        end
        PH_DIGITS: begin
          if (is_digit) begin
            digit_acc_next = acc_sum[23:0];
            if (acc_sum > {4'd0, NUM_LIMIT}) error_next = ERR_NUMBER;
          end else if (number_index != 2'd2) begin
            // close width or height, then treat this byte as a separator
            if ((digit_acc == 24'd0) || (digit_acc > DIM_LIMIT)) dims_bad_next = 1'b1;
            if (number_index == 2'd0) width_value_next  = digit_acc[15:0];
            else                      height_value_next = digit_acc[15:0];
            number_index_next = number_index + 2'd1;
            digit_acc_next    = 24'd0;
            phase_next        = PH_SKIP;
            do_skip           = 1'b1;
          end else begin
            // close maxval: dims and maxval first, then the one separator
            digit_acc_next = 24'd0;
            if (dims_bad || (digit_acc != MAXVAL_NEEDED)) error_next = ERR_DIMS;
            else if (is_ws)                                phase_next = PH_PIXELS;
            else                                           error_next = ERR_SEPARATOR;
          end
        end
        PH_PIXELS: begin
          if (~&pixel_counter) begin
            pixel_counter_next = pixel_counter + {{(COUNT_BITS-1){1'b0}}, 1'b1};
          end
        end
        default: begin
          error_next = ERR_MAGIC;
        end
      endcase

      if (do_skip && !is_ws) begin
        if (data_byte == CHAR_HASH) begin
          phase_next = PH_COMMENT;
        end else if (is_digit) begin
          digit_acc_next = {20'd0, data_byte[3:0]};
          phase_next     = PH_DIGITS;
        end else begin
          error_next = ERR_NUMBER;
        end
      end
    end

    // verdict as seen after this byte
    verdict_code = error_next;
    if (error_next == ERR_NONE) begin
      case (phase_next)
        PH_MAGIC_P, PH_MAGIC_5: verdict_code = ERR_MAGIC;
        PH_SKIP, PH_COMMENT:    verdict_code = ERR_NUMBER;
        PH_DIGITS: begin
          if (number_index_next != 2'd2)                           verdict_code = ERR_NUMBER;
          else if (dims_bad_next || (digit_acc_next != MAXVAL_NEEDED)) verdict_code = ERR_DIMS;
          else                                                     verdict_code = ERR_SEPARATOR;
        end
        PH_PIXELS: begin
          if (DIFF_W'(dims_product) > DIFF_W'(pixel_counter_next)) verdict_code = ERR_TRUNCATED;
        end
        default: verdict_code = ERR_MAGIC;
      endcase
    end
    if (byte_counter_next < COUNT_BITS'(MIN_FILE_BYTES)) verdict_code = ERR_MAGIC;
  end

  // byte_counter never trails pixel_counter, so the difference is the header length
  assign offset_wide = DIFF_W'(byte_counter_next) - DIFF_W'(pixel_counter_next);

  // -- parse state registers --------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst || (byte_accept && last_byte)) begin
      // drop all state: the next byte starts a new file
      phase         <= PH_MAGIC_P;
      number_index  <= 2'd0;
      digit_acc     <= 24'd0;
      width_value   <= 16'd0;
      height_value  <= 16'd0;
      dims_bad      <= 1'b0;
      byte_counter  <= '0;
      pixel_counter <= '0;
      first_error   <= ERR_NONE;
    end else if (byte_accept) begin
      phase         <= phase_next;
      number_index  <= number_index_next;
      digit_acc     <= digit_acc_next;
      width_value   <= width_value_next;
      height_value  <= height_value_next;
      dims_bad      <= dims_bad_next;
      byte_counter  <= byte_counter_next;
      pixel_counter <= pixel_counter_next;
      first_error   <= error_next;
    end
  end

  // dimensions settle at least two bytes before any pixel-count check
  always_ff @(posedge clk) begin
    dims_product <= {16'd0, width_value} * {16'd0, height_value};
  end

  // -- verdict register -------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      verdict_valid <= 1'b0;
    end else if (byte_accept && last_byte) begin
      verdict_valid <= 1'b1;
    end else if (!verdict_stall) begin
      verdict_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_accept && last_byte) begin
      error_code <= verdict_code;
      header_ok  <= (verdict_code == ERR_NONE);
      if (verdict_code == ERR_NONE) begin
        image_width  <= width_value_next;
        image_height <= height_value_next;
        pixel_offset <= offset_wide[31:0];
      end else begin
        image_width  <= 16'd0;
        image_height <= 16'd0;
        pixel_offset <= 32'd0;
      end
    end
  end

  // -- assertions -------------------------------------------------------------
  a_ok_matches_code: assert property (@(posedge clk) disable iff (rst)
    verdict_valid |-> (header_ok == (error_code == ERR_NONE)))
    else $error("header_ok disagrees with error_code");

  a_fail_zeroes: assert property (@(posedge clk) disable iff (rst)
    (verdict_valid && !header_ok) |->
      (image_width == 16'd0 && image_height == 16'd0 && pixel_offset == 32'd0))
    else $error("failed verdict carries non-zero payload");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    verdict_valid |-> (error_code <= ERR_TRUNCATED))
    else $error("error_code out of range");

  a_restart_after_last: assert property (@(posedge clk) disable iff (rst)
    (byte_accept && last_byte) |=>
      (phase == PH_MAGIC_P && byte_counter == '0 && first_error == ERR_NONE))
    else $error("parser not restarted after last byte");

  a_index_bound: assert property (@(posedge clk) disable iff (rst)
    number_index != 2'd3)
    else $error("number_index overran maxval");

  a_pixels_after_header: assert property (@(posedge clk) disable iff (rst)
    (pixel_counter != '0) |-> (phase == PH_PIXELS))
    else $error("pixel bytes counted outside pixel phase");

endmodule

`default_nettype wire
